// File: hdl/counter_based_random_stream_core_macros.svh
// Assertion macros shared by the random stream core.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef COUNTER_BASED_RANDOM_STREAM_CORE_MACROS_SVH
`define COUNTER_BASED_RANDOM_STREAM_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset
`define CBRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition at one edge implies consequence at the next
`define CBRS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define CBRS_ASSERT(lbl, prop, msg)
`define CBRS_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: hdl/cbrs_pkg.sv
package cbrs_pkg;

  // Default number of Philox rounds per block
  localparam int ROUND_COUNT_DEF = 10;

  // Field and register widths
  localparam int WORD_W   = 32;
  localparam int KEY_W    = 64;
  localparam int CFG_IDX_W = 1;
  localparam int POS_W    = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SEED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_ID = 1'd1;

  // Philox 4x32 constants
  localparam logic [WORD_W-1:0] MUL_A  = 32'hD2511F53;
  localparam logic [WORD_W-1:0] MUL_B  = 32'hCD9E8D57;
  localparam logic [WORD_W-1:0] BUMP_A = 32'h9E3779B9;
  localparam logic [WORD_W-1:0] BUMP_B = 32'hBB67AE85;

  // Buffer position meaning empty (four words consumed)
  localparam logic [POS_W-1:0] POS_EMPTY = 3'd4;

  typedef logic [3:0][WORD_W-1:0] words_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_ROUND
  } cbrs_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // start a refill from the counter block
    logic restart;  // clear block counter as part of the load
    logic read;     // serve a word from the buffer
    logic round;    // apply one round to the working words
    logic last;     // final round: fill buffer and deliver word 0
  } cbrs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_refill;
    logic out_valid;
  } cbrs_stat_t;

  // One Philox 4x32 round: two 32x32 products, then xor with key words
  function automatic words_t philox_round(words_t w, logic [WORD_W-1:0] ka,
                                          logic [WORD_W-1:0] kb);
    logic [2*WORD_W-1:0] pa;
    logic [2*WORD_W-1:0] pb;
    words_t n;
    pa = 64'(w[0]) * 64'(MUL_A);
    pb = 64'(w[2]) * 64'(MUL_B);
    n[0] = pb[2*WORD_W-1:WORD_W] ^ w[1] ^ ka;
    n[1] = pb[WORD_W-1:0];
    n[2] = pa[2*WORD_W-1:WORD_W] ^ w[3] ^ kb;
    n[3] = pa[WORD_W-1:0];
    return n;
  endfunction

endpackage

// File: hdl/cbrs_ctrl.sv
`include "counter_based_random_stream_core_macros.svh"

module cbrs_ctrl
  import cbrs_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       restart,
  input  logic       out_tready,
  input  cbrs_stat_t stat,
  output cbrs_cmd_t  cmd
);

  localparam int RND_W = $clog2(ROUND_COUNT);

  cbrs_state_t      state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             accept;
  logic             refill;
  logic             last_round;

  // Output register is free when empty or being taken this cycle
  assign in_tready  = (state_r == ST_IDLE) && (!stat.out_valid || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign refill     = restart || stat.need_refill;
  assign last_round = (state_r == ST_ROUND) && (rnd_r == RND_W'(ROUND_COUNT - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && refill) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (last_round) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd.load    = 1'b0;
    cmd.restart = restart;
    cmd.read    = 1'b0;
    cmd.round   = 1'b0;
    cmd.last    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = accept && refill;
        cmd.read = accept && !refill;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.last  = last_round;
      end
      default: ;
    endcase
  end

  // Round counter
  always_comb begin
    rnd_nxt = '0;
    if (state_r == ST_ROUND && !last_round) begin
      rnd_nxt = rnd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  `CBRS_ASSERT(a_rnd_range, (state_r != ST_ROUND) || (rnd_r <= RND_W'(ROUND_COUNT - 1)), "round counter out of range")
  `CBRS_ASSERT_NEXT(a_refill_start, accept && refill, state_r == ST_ROUND, "refill did not start")
  `CBRS_ASSERT(a_out_free, (state_r != ST_ROUND) || !stat.out_valid, "result pending during refill")

endmodule

// File: hdl/cbrs_datapath.sv
`include "counter_based_random_stream_core_macros.svh"

module cbrs_datapath
  import cbrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata,
  input  cbrs_cmd_t            cmd,
  output cbrs_stat_t           stat,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [WORD_W-1:0]    out_tdata
);

  logic [KEY_W-1:0]  key_seed_r;
  logic [KEY_W-1:0]  stream_id_r;
  logic [KEY_W-1:0]  block_counter_r;
  logic [POS_W-1:0]  pos_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  words_t            work_r;
  words_t            buf_r;
  words_t            round_nxt;
  logic [WORD_W-1:0] ka_r;
  logic [WORD_W-1:0] kb_r;
  logic [KEY_W-1:0]  ctr_base;

  assign ctr_base  = cmd.restart ? '0 : block_counter_r;
  assign round_nxt = philox_round(work_r, ka_r, kb_r);

  assign stat.need_refill = pos_r[POS_W-1];
  assign stat.out_valid   = out_valid_r;
  assign out_tvalid       = out_valid_r;
  assign out_tdata        = out_word_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_seed_r  <= '0;
      stream_id_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_SEED:  key_seed_r  <= cfg_wdata;
        REG_STREAM_ID: stream_id_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Block counter, buffer position and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_counter_r <= '0;
      pos_r           <= POS_EMPTY;
      out_valid_r     <= 1'b0;
    end else begin
      if (cmd.load) begin
        block_counter_r <= ctr_base;
      end else if (cmd.last) begin
        block_counter_r <= block_counter_r + 1'b1;
      end
      if (cmd.last) begin
        pos_r <= 3'd1;
      end else if (cmd.read) begin
        pos_r <= pos_r + 1'b1;
      end
      if (cmd.last || cmd.read) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Round unit working words, keys, buffer and output word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r <= {stream_id_r[63:32], stream_id_r[31:0], ctr_base[63:32], ctr_base[31:0]};
      ka_r   <= key_seed_r[31:0];
      kb_r   <= key_seed_r[63:32];
    end else if (cmd.round) begin
      work_r <= round_nxt;
      ka_r   <= ka_r + BUMP_A;
      kb_r   <= kb_r + BUMP_B;
    end
    if (cmd.last) begin
      buf_r      <= round_nxt;
      out_word_r <= round_nxt[0];
    end else if (cmd.read) begin
      out_word_r <= buf_r[pos_r[1:0]];
    end
  end

  `CBRS_ASSERT(a_pos_range, pos_r <= POS_EMPTY, "buffer position beyond empty")
  `CBRS_ASSERT_NEXT(a_fill_out, cmd.last, (pos_r == 3'd1) && out_valid_r, "refill did not deliver")

endmodule

// File: hdl/counter_based_random_stream_core.sv
// Output: a word served from the buffer is valid the cycle after acceptance;
//   a word that needs a refill is valid once the load and all ROUND_COUNT rounds
//   have run. No request is taken while a refill runs; its rounds go through
//   the one round unit with its two 32x32 multipliers.
// Reset (rst_n, synchronous): key and stream id zero, counter zero, buffer empty.
module counter_based_random_stream_core
  import cbrs_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] restart, [7:1] zero
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [WORD_W-1:0]    out_tdata,  // [31:0] random_word
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata
);

  cbrs_cmd_t  cmd;
  cbrs_stat_t stat;

  // Sequencer
  cbrs_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .restart    (in_tdata[0]),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Round unit, buffer and output register
  cbrs_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// File: tb/cbrs_word_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register ports, predicts each word and
// compares it with what the core delivers.
module cbrs_word_checker
  import cbrs_pkg::*;
#(
  parameter int ROUNDS = ROUND_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] restart, [7:1] zero
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [WORD_W-1:0]    out_tdata,  // [31:0] random_word
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output logic                 busy
);

  // Shadow of the core's registers and state
  logic [KEY_W-1:0] key_seed_q;
  logic [KEY_W-1:0] stream_id_q;
  logic [63:0]      block_ctr;
  words_t           word_buf;
  int               buf_pos;

  logic [WORD_W-1:0] expected_words[$];
  int unsigned       items_in;
  int unsigned       words_out;

  assign busy = (items_in != words_out);

  // Philox 4x32 over one counter block
  function automatic words_t philox_block(logic [63:0] ctr, logic [63:0] sid,
                                          logic [63:0] key);
    words_t      w;
    words_t      nx;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [63:0] pa;
    logic [63:0] pb;
    w[0] = ctr[31:0];
    w[1] = ctr[63:32];
    w[2] = sid[31:0];
    w[3] = sid[63:32];
    ka   = key[31:0];
    kb   = key[63:32];
    for (int r = 0; r < ROUNDS; r++) begin
      pa    = {32'd0, w[0]} * {32'd0, MUL_A};
      pb    = {32'd0, w[2]} * {32'd0, MUL_B};
      nx[0] = pb[63:32] ^ w[1] ^ ka;
      nx[1] = pb[31:0];
      nx[2] = pa[63:32] ^ w[3] ^ kb;
      nx[3] = pa[31:0];
      w     = nx;
      ka    = ka + BUMP_A;
      kb    = kb + BUMP_B;
    end
    return w;
  endfunction

  // Register writes, word prediction and result comparison
  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (!rst_n) begin
      key_seed_q  = '0;
      stream_id_q = '0;
      block_ctr   = '0;
      word_buf    = '0;
      buf_pos     = int'(POS_EMPTY);
      expected_words.delete();
      items_in   <= 0;
      words_out  <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_SEED:  key_seed_q  = cfg_wdata;
          REG_STREAM_ID: stream_id_q = cfg_wdata;
          default: ;
        endcase
      end

      // requested item: restart first, then refill when empty
      if (in_tvalid && in_tready) begin
        if (in_tdata[0]) begin
          block_ctr = '0;
          buf_pos   = int'(POS_EMPTY);
        end
        if (buf_pos >= int'(POS_EMPTY)) begin
          word_buf  = philox_block(block_ctr, stream_id_q, key_seed_q);
          buf_pos   = 0;
          block_ctr = block_ctr + 64'd1;
        end
        expected_words.push_back(word_buf[buf_pos[1:0]]);
        buf_pos  = buf_pos + 1;
        items_in <= items_in + 1;
      end

      // delivered word against the oldest prediction
      if (out_tvalid && out_tready) begin
        words_out <= words_out + 1;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $realtime, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: random_word expected %h actual %h", $realtime, want,
                     out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/tb_counter_based_random_stream_core.sv
`timescale 1ns / 1ps

module tb_counter_based_random_stream_core;
  import cbrs_pkg::*;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = 8'd0;   // [0] restart, [7:1] zero
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [WORD_W-1:0]    out_tdata;           // [31:0] random_word
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_KEY_SEED;
  logic [KEY_W-1:0]     cfg_wdata  = '0;

  int   fail_count;
  logic busy;

  // sender and receiver pacing
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold   = 0;
  int rx_cycle  = 0;

  always #2 clk = ~clk;

  counter_based_random_stream_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  cbrs_word_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .busy       (busy)
  );

  // Receiver: short stalls mostly, the odd long one, stretches with none
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 400 == 399) begin
      rx_steady <= ($urandom_range(0, 3) == 0);
    end
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold    <= rx_hold - 1;
    end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      rx_hold    <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One word request; a final item of a burst always leaves valid low
  task automatic request_word(bit restart, bit last_of_burst);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = pick_gap();
    if (last_of_burst && gap == 0) gap = 1;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Every requested word delivered
  task automatic wait_drained();
    do @(posedge clk); while (busy);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int               n;
    int               restart_pct;
    logic [KEY_W-1:0] key_v;
    logic [KEY_W-1:0] sid_v;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: refills from reset, restarts mid-buffer and back to back
    repeat (6) request_word(1'b0, 1'b0);
    request_word(1'b1, 1'b0);
    request_word(1'b0, 1'b0);
    request_word(1'b0, 1'b0);
    request_word(1'b1, 1'b0);
    request_word(1'b1, 1'b0);
    request_word(1'b0, 1'b1);
    // key change while words are buffered: old words first, new key at refill
    wait_drained();
    cfg_write(REG_KEY_SEED, '1);
    repeat (4) request_word(1'b0, 1'b0);
    request_word(1'b0, 1'b1);
    wait_drained();
    cfg_write(REG_STREAM_ID, '1);
    repeat (3) request_word(1'b0, 1'b0);
    request_word(1'b1, 1'b0);
    request_word(1'b0, 1'b1);

    // Random phases under different register settings
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0: begin key_v = '0; sid_v = '0; end
        1: begin key_v = '1; sid_v = '0; end
        2: begin key_v = '0; sid_v = '1; end
        default: begin
          key_v = {$urandom, $urandom};
          sid_v = {$urandom, $urandom};
        end
      endcase
      cfg_write(REG_KEY_SEED, key_v);
      cfg_write(REG_STREAM_ID, sid_v);
      tx_steady   = (p == 4);
      restart_pct = (p == 3) ? 40 : 8;
      for (n = 0; n < 100; n++) begin
        request_word($urandom_range(0, 99) < restart_pct, n == 99 || n % 37 == 36);
        // sender holds off until the core has caught up
        if (n % 37 == 36) begin
          wait_drained();
          if (p == 5) cfg_write(REG_KEY_SEED, {$urandom, $urandom});
          if (p == 5 && n > 40) cfg_write(REG_STREAM_ID, {$urandom, $urandom});
        end
      end
    end

    // Drain and verdict
    n = 0;
    while (busy && n < 20000) begin
      @(posedge clk);
      n++;
    end
    if (busy) begin
      $display("tb: failure");
      $finish;
    end else begin
      repeat (ROUND_COUNT_DEF + 8) @(posedge clk);
      if (fail_count == 0 && !busy) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
      $finish;
    end
  end

  // Run limit
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
